### rtl/cpac_pkg.sv
package cpac_pkg;

  // pixel and arithmetic widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ProdW    = 16;
  localparam int unsigned RecipW   = 24;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned CfgIdxW  = 2;

  // fixed values of the conversion
  localparam logic [ByteW-1:0]  FULL_ALPHA  = 8'hFF;
  localparam logic [ProdW-1:0]  PREMUL_BIAS = 16'd254;
  // ceil(2^24 / 255), exact floor division by 255 for every premultiply sum
  localparam logic [RecipW-1:0] DIV255_MUL  = 24'd65794;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SURFACE_ORDER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_CONVERT = 2'd1;

  // per item control that travels along the pipeline
  typedef struct packed {
    logic             write;
    logic             conv;
    logic             bgra;
    logic [ByteW-1:0] alpha;
  } ctrl_t;

endpackage

### rtl/cpac_lane.sv
module cpac_lane
  import cpac_pkg::*;
(
  input  logic              clk_i,
  input  logic              s2_load_i,
  input  logic              s3_load_i,
  input  logic [ByteW-1:0]  color_i,
  input  logic [ByteW-1:0]  alpha_i,
  input  logic              write_i,
  input  logic [RecipW-1:0] recip_i,
  input  logic              conv_i,
  output logic [ByteW-1:0]  result_o
);

  logic [ProdW-1:0]        n_d, n_q;
  logic [RecipW-1:0]       mul_d, mul_q;
  logic                    sat_d, sat_q;
  logic [ByteW-1:0]        c2_q;
  logic [ProdW+RecipW-1:0] prod;
  logic [ByteW-1:0]        quo_q, c3_q;
  logic                    sat3_q;

  // first product: color times 255 on read, color times alpha plus bias on write
  always_comb begin
    if (write_i) begin
      n_d   = ProdW'(color_i) * ProdW'(alpha_i) + PREMUL_BIAS;
      mul_d = DIV255_MUL;
      sat_d = 1'b0;
    end else begin
      n_d   = {color_i, {ByteW{1'b0}}} - {{(ProdW-ByteW){1'b0}}, color_i};
      mul_d = recip_i;
      // color at or above alpha gives a quotient of at least 255
      sat_d = (color_i >= alpha_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load_i) begin
      n_q   <= n_d;
      mul_q <= mul_d;
      sat_q <= sat_d;
      c2_q  <= color_i;
    end
  end

  // division as multiply by reciprocal
  assign prod = {{RecipW{1'b0}}, n_q} * {{ProdW{1'b0}}, mul_q};

  always_ff @(posedge clk_i) begin
    if (s3_load_i) begin
      quo_q  <= prod[RecipShift +: ByteW];
      sat3_q <= sat_q;
      c3_q   <= c2_q;
    end
  end

  // pass through, saturate or take the quotient
  always_comb begin
    if (!conv_i) begin
      result_o = c3_q;
    end else if (sat3_q) begin
      result_o = FULL_ALPHA;
    end else begin
      result_o = quo_q;
    end
  end

endmodule

### rtl/cpac_merge.sv
module cpac_merge
  import cpac_pkg::*;
(
  input  logic             clk_i,
  input  logic             load_i,
  input  ctrl_t            ctrl_i,
  input  logic [ByteW-1:0] red_i,
  input  logic [ByteW-1:0] green_i,
  input  logic [ByteW-1:0] blue_i,
  output logic [ByteW-1:0] out_byte0_o,
  output logic [ByteW-1:0] out_byte1_o,
  output logic [ByteW-1:0] out_byte2_o,
  output logic [ByteW-1:0] out_byte3_o
);

  logic [ByteW-1:0] b0_q, b1_q, b2_q, b3_q;
  logic             swap;

  // writes to a bgra surface go out in b,g,r order
  assign swap = ctrl_i.write & ctrl_i.bgra;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b0_q <= swap ? blue_i : red_i;
      b1_q <= green_i;
      b2_q <= swap ? red_i : blue_i;
      b3_q <= ctrl_i.alpha;
    end
  end

  assign out_byte0_o = b0_q;
  assign out_byte1_o = b1_q;
  assign out_byte2_o = b2_q;
  assign out_byte3_o = b3_q;

endmodule

### rtl/canvas_pixel_alpha_convert.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    command_i, in_byte0_i .. in_byte3_i
// out       output     out_valid_o / out_ready_i  out_byte0_o .. out_byte3_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item per cycle while the output is not stalled
// stages: input register with reciprocal lookup, first product, reciprocal
// multiply, output register; three color lanes run side by side
// a stage takes a new item whenever it is empty or its item moves on, so
// bubbles close up under output stalls
// reset empties the pipeline and sets both config bits to one
module canvas_pixel_alpha_convert
  import cpac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [ByteW-1:0]   in_byte0_i,
  input  logic [ByteW-1:0]   in_byte1_i,
  input  logic [ByteW-1:0]   in_byte2_i,
  input  logic [ByteW-1:0]   in_byte3_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   out_byte0_o,
  output logic [ByteW-1:0]   out_byte1_o,
  output logic [ByteW-1:0]   out_byte2_o,
  output logic [ByteW-1:0]   out_byte3_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i
);

  logic              bgra_q, conv_en_q;
  logic              v1_q, v2_q, v3_q, v4_q;
  logic              mov1, mov2, mov3, mov4, accept;
  ctrl_t             ctrl_d, ctrl1_q, ctrl2_q, ctrl3_q;
  logic [ByteW-1:0]  color_d [NumLanes];
  logic [ByteW-1:0]  color1_q [NumLanes];
  logic [ByteW-1:0]  result [NumLanes];
  logic [RecipW-1:0] recip_tbl [256];
  logic [RecipW-1:0] recip1_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bgra_q    <= 1'b1;
      conv_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SURFACE_ORDER) begin
        bgra_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_ALPHA_CONVERT) begin
        conv_en_q <= cfg_data_i;
      end
    end
  end

  // reciprocal table, ceil(2^24 / alpha); entries for alpha below two are zero
  for (genvar i = 0; i < 256; i++) begin : g_recip
    localparam int unsigned Div = (i < 2) ? 1 : i;
    localparam int unsigned Val = (i < 2) ? 0 : ((1 << RecipShift) + Div - 1) / Div;
    assign recip_tbl[i] = RecipW'(Val);
  end

  // pipeline flow, a stage moves when the next one is free
  assign mov4       = v4_q & out_ready_i;
  assign mov3       = v3_q & (~v4_q | mov4);
  assign mov2       = v2_q & (~v3_q | mov3);
  assign mov1       = v1_q & (~v2_q | mov2);
  assign in_ready_o = ~v1_q | mov1;
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept | (v1_q & ~mov1);
      v2_q <= mov1 | (v2_q & ~mov2);
      v3_q <= mov2 | (v3_q & ~mov3);
      v4_q <= mov3 | (v4_q & ~mov4);
    end
  end

  assign out_valid_o = v4_q;

  // item decode: color order and whether alpha conversion applies
  always_comb begin
    ctrl_d.write = command_i;
    ctrl_d.bgra  = bgra_q;
    ctrl_d.alpha = in_byte3_i;
    if (command_i) begin
      ctrl_d.conv = conv_en_q & (in_byte3_i != FULL_ALPHA);
    end else begin
      ctrl_d.conv = conv_en_q & (in_byte3_i != FULL_ALPHA) & (in_byte3_i != '0);
    end
    color_d[1] = in_byte1_i;
    if (!command_i && bgra_q) begin
      color_d[0] = in_byte2_i;
      color_d[2] = in_byte0_i;
    end else begin
      color_d[0] = in_byte0_i;
      color_d[2] = in_byte2_i;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl1_q  <= ctrl_d;
      color1_q <= color_d;
      recip1_q <= recip_tbl[in_byte3_i];
    end
  end

  // control follows the lanes
  always_ff @(posedge clk_i) begin
    if (mov1) begin
      ctrl2_q <= ctrl1_q;
    end
    if (mov2) begin
      ctrl3_q <= ctrl2_q;
    end
  end

  // one lane per color
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    cpac_lane u_lane (
      .clk_i     (clk_i),
      .s2_load_i (mov1),
      .s3_load_i (mov2),
      .color_i   (color1_q[l]),
      .alpha_i   (ctrl1_q.alpha),
      .write_i   (ctrl1_q.write),
      .recip_i   (recip1_q),
      .conv_i    (ctrl3_q.conv),
      .result_o  (result[l])
    );
  end

  // swizzle and output register
  cpac_merge u_merge (
    .clk_i       (clk_i),
    .load_i      (mov3),
    .ctrl_i      (ctrl3_q),
    .red_i       (result[0]),
    .green_i     (result[1]),
    .blue_i      (result[2]),
    .out_byte0_o (out_byte0_o),
    .out_byte1_o (out_byte1_o),
    .out_byte2_o (out_byte2_o),
    .out_byte3_o (out_byte3_o)
  );

endmodule

### tb/tb.sv
module tb;
  import cpac_pkg::*;

  // command codes of the input item
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register indexes past the end of the register list
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned STALL_LEN    = 200;

  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b3;
  } pixel_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             command_i   = CMD_READ;
  logic [ByteW-1:0] in_byte0_i  = '0;
  logic [ByteW-1:0] in_byte1_i  = '0;
  logic [ByteW-1:0] in_byte2_i  = '0;
  logic [ByteW-1:0] in_byte3_i  = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ByteW-1:0] out_byte0_o;
  logic [ByteW-1:0] out_byte1_o;
  logic [ByteW-1:0] out_byte2_o;
  logic [ByteW-1:0] out_byte3_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic             cfg_data_i  = 1'b0;

  // predictor copy of the two register bits, reset values
  logic surface_bgra = 1'b1;
  logic alpha_conv   = 1'b1;

  pixel_t converted_pixels[$];

  int unsigned in_idle_pct  = 35;
  int unsigned out_idle_pct = 35;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned n_reads      = 0;
  int unsigned n_writes     = 0;
  int unsigned n_cfg_writes = 0;

  canvas_pixel_alpha_convert dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .in_byte0_i  (in_byte0_i),
    .in_byte1_i  (in_byte1_i),
    .in_byte2_i  (in_byte2_i),
    .in_byte3_i  (in_byte3_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte0_o (out_byte0_o),
    .out_byte1_o (out_byte1_o),
    .out_byte2_o (out_byte2_o),
    .out_byte3_o (out_byte3_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // color from premultiplied back to straight, clamped at full scale
  function automatic int unsigned unpremultiply(input int unsigned c, input int unsigned a);
    int unsigned q;
    q = (c * 32'(FULL_ALPHA)) / a;
    if (q > 32'(FULL_ALPHA)) q = 32'(FULL_ALPHA);
    return q;
  endfunction

  // straight color scaled by alpha, rounded up by the bias
  function automatic int unsigned premultiply(input int unsigned c, input int unsigned a);
    return (c * a + 32'(PREMUL_BIAS)) / 32'(FULL_ALPHA);
  endfunction

  // expected output pixel for one input pixel under the current settings
  function automatic pixel_t convert_pixel(input logic cmd, input logic [ByteW-1:0] b0,
                                           input logic [ByteW-1:0] b1,
                                           input logic [ByteW-1:0] b2,
                                           input logic [ByteW-1:0] alpha);
    int unsigned r, g, b, a;
    pixel_t px;
    a = 32'(alpha);
    if (cmd == CMD_READ) begin
      // surface order to r,g,b, then undo premultiply
      if (surface_bgra) begin
        r = 32'(b2); g = 32'(b1); b = 32'(b0);
      end else begin
        r = 32'(b0); g = 32'(b1); b = 32'(b2);
      end
      if (alpha_conv && a != 0 && a != FULL_ALPHA) begin
        r = unpremultiply(r, a);
        g = unpremultiply(g, a);
        b = unpremultiply(b, a);
      end
      px.b0 = r[ByteW-1:0];
      px.b1 = g[ByteW-1:0];
      px.b2 = b[ByteW-1:0];
    end else begin
      // premultiply, then r,g,b to surface order
      r = 32'(b0); g = 32'(b1); b = 32'(b2);
      if (alpha_conv && a != FULL_ALPHA) begin
        r = premultiply(r, a);
        g = premultiply(g, a);
        b = premultiply(b, a);
      end
      if (surface_bgra) begin
        px.b0 = b[ByteW-1:0]; px.b1 = g[ByteW-1:0]; px.b2 = r[ByteW-1:0];
      end else begin
        px.b0 = r[ByteW-1:0]; px.b1 = g[ByteW-1:0]; px.b2 = b[ByteW-1:0];
      end
    end
    px.b3 = alpha;
    return px;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // offer one pixel, with a random gap first; returns at the falling edge
  // after acceptance, valid still high
  task automatic send_pixel(input logic cmd, input logic [ByteW-1:0] b0,
                            input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2,
                            input logic [ByteW-1:0] alpha);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    in_byte0_i <= b0;
    in_byte1_i <= b1;
    in_byte2_i <= b2;
    in_byte3_i <= alpha;
    do @(posedge clk_i); while (!in_ready_o);
    converted_pixels.push_back(convert_pixel(cmd, b0, b1, b2, alpha));
    if (cmd == CMD_READ) n_reads++;
    else n_writes++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  // color mostly within alpha, as a premultiplied surface holds, sometimes anything
  function automatic logic [ByteW-1:0] random_color(input logic [ByteW-1:0] alpha);
    if ($urandom_range(3) == 0) return ByteW'($urandom_range(255));
    return ByteW'($urandom_range(32'(alpha)));
  endfunction

  task automatic send_random_pixel();
    logic cmd;
    logic [ByteW-1:0] alpha;
    int unsigned pick;
    cmd  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 10) alpha = '0;
    else if (pick < 20) alpha = FULL_ALPHA;
    else if (pick < 25) alpha = 8'd1;
    else alpha = ByteW'($urandom_range(255));
    send_pixel(cmd, random_color(alpha), random_color(alpha), random_color(alpha), alpha);
  endtask

  // wait for every result, then let the pipeline empty out
  task automatic wait_drained();
    while (converted_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SURFACE_ORDER: surface_bgra = value;
      CFG_ALPHA_CONVERT: alpha_conv = value;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // idle rates change at a rising edge so the driving processes see them cleanly
  task automatic set_idling(input int unsigned in_pct, input int unsigned out_pct);
    @(posedge clk_i);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    @(negedge clk_i);
  endtask

  // extremes of alpha and color in both directions at reset settings
  task automatic test_directed();
    send_pixel(CMD_READ,  8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(CMD_READ,  8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(CMD_READ,  8'd200, 8'd100, 8'd50,  8'd0);
    send_pixel(CMD_READ,  8'd10,  8'd20,  8'd30,  8'd255);
    send_pixel(CMD_READ,  8'd255, 8'd255, 8'd255, 8'd1);
    send_pixel(CMD_READ,  8'd1,   8'd0,   8'd1,   8'd1);
    send_pixel(CMD_READ,  8'd64,  8'd32,  8'd128, 8'd128);
    send_pixel(CMD_READ,  8'd200, 8'd10,  8'd255, 8'd100);
    send_pixel(CMD_READ,  8'd254, 8'd253, 8'd127, 8'd254);
    send_pixel(CMD_READ,  8'h55,  8'hAA,  8'h55,  8'hAA);
    send_pixel(CMD_READ,  8'hAA,  8'h55,  8'hAA,  8'h55);
    send_pixel(CMD_WRITE, 8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(CMD_WRITE, 8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(CMD_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(CMD_WRITE, 8'd255, 8'd128, 8'd1,   8'd1);
    send_pixel(CMD_WRITE, 8'd255, 8'd1,   8'd0,   8'd254);
    send_pixel(CMD_WRITE, 8'd1,   8'd1,   8'd1,   8'd1);
    send_pixel(CMD_WRITE, 8'h55,  8'hAA,  8'h55,  8'hAA);
    send_pixel(CMD_WRITE, 8'hAA,  8'h55,  8'hAA,  8'h55);
    send_pixel(CMD_WRITE, 8'd17,  8'd34,  8'd51,  8'd128);
    stop_sending();
  endtask

  // all four byte order / conversion settings, then writes to spare indexes
  task automatic test_register_settings();
    for (int s = 0; s < 4; s++) begin
      write_register(CFG_SURFACE_ORDER, s[1]);
      write_register(CFG_ALPHA_CONVERT, s[0]);
      repeat (190) send_random_pixel();
      stop_sending();
    end
    // spare indexes must leave both bits set
    write_register(CFG_SPARE_A, 1'b0);
    write_register(CFG_SPARE_B, 1'b0);
    repeat (20) send_random_pixel();
    stop_sending();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    @(posedge clk_i);
    stall_left  = STALL_LEN;
    in_idle_pct = 0;
    @(negedge clk_i);
    repeat (80) send_random_pixel();
    stop_sending();
    set_idling(35, 35);
  endtask

  // sender stops until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    repeat (40) send_random_pixel();
    stop_sending();
    while (converted_pixels.size() != 0) @(negedge clk_i);
    repeat (40) send_random_pixel();
    stop_sending();
  endtask

  // back to back stretch with no idling, then random idling again
  task automatic test_random_stream();
    set_idling(0, 0);
    repeat (100) send_random_pixel();
    stop_sending();
    set_idling(35, 35);
    repeat (60) send_random_pixel();
    stop_sending();
  endtask

  // receiver side: random ready, or a counted hold-off
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // compare each output pixel with the oldest prediction
  always @(posedge clk_i) begin : check_results
    pixel_t want;
    pixel_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_byte0_o, out_byte1_o, out_byte2_o, out_byte3_o};
      if (converted_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel %h %h %h %h",
                             got.b0, got.b1, got.b2, got.b3));
      end else begin
        want = converted_pixels.pop_front();
        if (got.b0 !== want.b0 || got.b1 !== want.b1 ||
            got.b2 !== want.b2 || got.b3 !== want.b3) begin
          flag_error($sformatf("pixel mismatch: expected %h %h %h %h, got %h %h %h %h",
                               want.b0, want.b1, want.b2, want.b3,
                               got.b0, got.b1, got.b2, got.b3));
        end
      end
    end
  end

  // end the run if no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d pixels outstanding",
               QUIET_LIMIT, converted_pixels.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_register_settings();
    test_output_backpressure();
    test_drain_pause();
    test_random_stream();
    wait_drained();
    $display("checked %0d reads and %0d writes across %0d register writes and all four settings",
             n_reads, n_writes, n_cfg_writes);
    $display("incl. zero, opaque and saturating alpha, a %0d cycle output stall and a drain pause",
             STALL_LEN);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/cpac_pkg.sv
rtl/cpac_lane.sv
rtl/cpac_merge.sv
rtl/canvas_pixel_alpha_convert.sv
tb/tb.sv
